/* rtl/hrit_pkg.sv */
`default_nettype none
// ============================================================================
// hrit_pkg
// Shared types and constants of the homography reprojection inlier test:
// datapath widths, counter limits, register map and sequencer states.
// ============================================================================
package hrit_pkg;

    // Longest correspondence set that the counters track
    localparam int MAX_PAIRS = 65536;

    localparam int IDX_TOP_INT   = ((MAX_PAIRS - 1) > 65535) ? 65535 : (MAX_PAIRS - 1);
    localparam int TALLY_TOP_INT = (MAX_PAIRS > 65536) ? 65536 : MAX_PAIRS;

    localparam logic [15:0] IDX_TOP   = 16'(IDX_TOP_INT);
    localparam logic [16:0] TALLY_TOP = 17'(TALLY_TOP_INT);

    // Numerator and denominator sums, 20 and 34 fraction bits
    localparam int NUM_W = 52;
    // Divisor aligned to the top quotient bit, and the partial remainder
    localparam int DVS_W = 72;
    localparam int REM_W = 73;
    // 22 integer and 19 fraction quotient bits
    localparam int Q_W   = 41;
    localparam int PX_W  = 42;
    localparam int DIF_W = 43;

    localparam logic [NUM_W-1:0] DEN_ONE  = {{(NUM_W - 35){1'b0}}, 1'b1, 34'b0};
    localparam logic [Q_W-1:0]   PX_CLAMP = {1'b1, {(Q_W - 1){1'b0}}};
    localparam logic [31:0]      ERR_SAT  = 32'hFFFF_FFFF;

    // Sequencer step limits
    localparam logic [5:0] MAC_LAST = 6'd7;
    localparam logic [5:0] DIV_LAST = 6'd40;

    // Configuration register map (index = paddr[5:3])
    localparam int CFG_ADDR_W = 6;
    localparam logic [2:0] REG_H_XX    = 3'd0;
    localparam logic [2:0] REG_H_XY    = 3'd1;
    localparam logic [2:0] REG_H_XT    = 3'd2;
    localparam logic [2:0] REG_H_YX    = 3'd3;
    localparam logic [2:0] REG_H_YY    = 3'd4;
    localparam logic [2:0] REG_H_YT    = 3'd5;
    localparam logic [2:0] REG_H_PERSP = 3'd6;
    localparam logic [2:0] REG_RADIUS  = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAC,
        ST_DIV_INIT,
        ST_CHECK,
        ST_DIV,
        ST_ROUND,
        ST_DIFF,
        ST_SQUARE,
        ST_ACCUM,
        ST_FINISH
    } state_t;

endpackage
`default_nettype wire

/* rtl/homography_reprojection_inlier_test.sv */
`default_nettype none
// ============================================================================
// homography_reprojection_inlier_test
// Maps a source point through a configured homography, squares the distance
// to the target point and flags inliers, keeping a per-set index and count.
// ============================================================================
// One word in gives one word out. Multiply-accumulate on one shared 32x18
// multiplier forms the denominator, both numerators and the squared radius,
// then each mapped coordinate runs through a restoring divider that retires
// one quotient bit per cycle (41 steps) plus setup, overflow check,
// rounding, difference, squaring and accumulation, and the result is loaded
// into the output register. The next word can be accepted in the cycle after
// the load; a result that still waits in the output register holds the
// finishing step. A coordinate whose quotient overflows skips the 41 steps,
// and a zero denominator goes from the multiply-accumulate steps straight to
// the finishing step. The divider sets the pace: in_ready is high only
// between words.
module homography_reprojection_inlier_test
    import hrit_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [63:0]           pwdata,
    output logic      [63:0]           prdata,
    output logic                       pready,
    // Correspondence input
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic signed [17:0]    from_x,
    input  wire logic signed [17:0]    from_y,
    input  wire logic signed [17:0]    to_x,
    input  wire logic signed [17:0]    to_y,
    input  wire logic                  last_pair,
    // Result output
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic      [15:0]           pair_index,
    output logic      [31:0]           err_sq,
    output logic                       is_inlier,
    output logic      [16:0]           inlier_count,
    output logic                       end_of_set
);

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    logic signed [31:0] h_xx_reg, h_xy_reg, h_xt_reg;
    logic signed [31:0] h_yx_reg, h_yy_reg, h_yt_reg;
    logic        [63:0] h_persp_reg;
    logic        [15:0] radius_reg;
    logic               cfg_wr;

    state_t state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;

    logic signed [17:0] x_reg, y_reg, tx_reg, ty_reg;
    logic signed [17:0] x_next, y_next, tx_next, ty_next;
    logic               last_reg, last_next;

    logic signed [31:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [49:0] mul_p;
    logic signed [49:0] prod_reg, prod_next;
    logic [NUM_W-1:0]   prod_ext;

    logic [NUM_W-1:0] den_reg, den_next, nx_reg, nx_next, ny_reg, ny_next;
    logic [31:0]      r2_reg, r2_next;

    logic [NUM_W-1:0] num_sel, num_mag, den_mag;
    logic [REM_W-1:0] rem_reg, rem_next, rem_sub;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [Q_W-1:0]   q_reg, q_next, q_mag;
    logic [Q_W:0]     q_sum;
    logic             neg_reg, neg_next, ovf_reg, ovf_next;
    logic             div_ge;

    logic [PX_W-1:0]  px_reg, px_next;
    logic [DIF_W-1:0] diff_reg, diff_next, diff_mag;
    logic [17:0]      t_sel;

    logic [32:0] err_acc_reg, err_acc_next;
    logic        sat_reg, sat_next, coord_reg, coord_next;

    logic [15:0] index_reg, index_next;
    logic [16:0] tally_reg, tally_next, tally_inc;
    logic [31:0] err_final;
    logic        inl_final, out_free, finish_fire;

    logic        out_valid_reg, out_valid_next;
    logic [15:0] pair_index_reg, pair_index_next;
    logic [31:0] err_sq_reg, err_sq_next;
    logic        is_inlier_reg, is_inlier_next;
    logic [16:0] inlier_count_reg, inlier_count_next;
    logic        end_of_set_reg, end_of_set_next;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_xx_reg    <= 32'sd65536;
            h_xy_reg    <= '0;
            h_xt_reg    <= '0;
            h_yx_reg    <= '0;
            h_yy_reg    <= 32'sd65536;
            h_yt_reg    <= '0;
            h_persp_reg <= '0;
            radius_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[5:3])
                REG_H_XX:    h_xx_reg    <= pwdata[31:0];
                REG_H_XY:    h_xy_reg    <= pwdata[31:0];
                REG_H_XT:    h_xt_reg    <= pwdata[31:0];
                REG_H_YX:    h_yx_reg    <= pwdata[31:0];
                REG_H_YY:    h_yy_reg    <= pwdata[31:0];
                REG_H_YT:    h_yt_reg    <= pwdata[31:0];
                REG_H_PERSP: h_persp_reg <= pwdata;
                REG_RADIUS:  radius_reg  <= pwdata[15:0];
                default:     ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (paddr[5:3])
            REG_H_XX:    prdata = {32'b0, h_xx_reg};
            REG_H_XY:    prdata = {32'b0, h_xy_reg};
            REG_H_XT:    prdata = {32'b0, h_xt_reg};
            REG_H_YX:    prdata = {32'b0, h_yx_reg};
            REG_H_YY:    prdata = {32'b0, h_yy_reg};
            REG_H_YT:    prdata = {32'b0, h_yt_reg};
            REG_H_PERSP: prdata = h_persp_reg;
            REG_RADIUS:  prdata = {48'b0, radius_reg};
            default:     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Shared multiplier: operand select by sequencer step
    // ------------------------------------------------------------------
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_MAC)
        begin
            case (cnt_reg)
                6'd0:
                begin
                    mul_a = $signed(h_persp_reg[31:0]);
                    mul_b = x_reg;
                end
                6'd1:
                begin
                    mul_a = $signed(h_persp_reg[63:32]);
                    mul_b = y_reg;
                end
                6'd2:
                begin
                    mul_a = h_xx_reg;
                    mul_b = x_reg;
                end
                6'd3:
                begin
                    mul_a = h_xy_reg;
                    mul_b = y_reg;
                end
                6'd4:
                begin
                    mul_a = h_yx_reg;
                    mul_b = x_reg;
                end
                6'd5:
                begin
                    mul_a = h_yy_reg;
                    mul_b = y_reg;
                end
                6'd6:
                begin
                    mul_a = $signed({16'b0, radius_reg});
                    mul_b = $signed({2'b0, radius_reg});
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
        else if (state_reg == ST_SQUARE)
        begin
            mul_a = $signed({15'b0, diff_mag[16:0]});
            mul_b = $signed({1'b0, diff_mag[16:0]});
        end
    end

    assign mul_p    = mul_a * mul_b;
    assign prod_ext = {{(NUM_W - 50){prod_reg[49]}}, prod_reg};

    // ------------------------------------------------------------------
    // Helper terms
    // ------------------------------------------------------------------
    assign num_sel  = coord_reg ? ny_reg : nx_reg;
    assign num_mag  = num_sel[NUM_W-1] ? (~num_sel + 1'b1) : num_sel;
    assign den_mag  = den_reg[NUM_W-1] ? (~den_reg + 1'b1) : den_reg;
    assign div_ge   = (rem_reg >= {1'b0, dvs_reg});
    assign rem_sub  = div_ge ? (rem_reg - {1'b0, dvs_reg}) : rem_reg;
    assign q_sum    = {1'b0, q_reg} + {{Q_W{1'b0}}, 1'b1};
    assign q_mag    = ovf_reg ? PX_CLAMP : q_sum[Q_W:1];
    assign t_sel    = coord_reg ? ty_reg : tx_reg;
    assign diff_mag = diff_reg[DIF_W-1] ? (~diff_reg + 1'b1) : diff_reg;

    // Final error, inlier flag and tally for the word being finished
    assign err_final   = (sat_reg || err_acc_reg[32]) ? ERR_SAT : err_acc_reg[31:0];
    assign inl_final   = (err_final < r2_reg);
    assign tally_inc   = (inl_final && (tally_reg < TALLY_TOP)) ? (tally_reg + 17'd1)
                                                                 : tally_reg;
    assign out_free    = !out_valid_reg || out_ready;
    assign finish_fire = (state_reg == ST_FINISH) && out_free;

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_MAC;
            end
            ST_MAC:
            begin
                if (cnt_reg == MAC_LAST)
                    state_next = (den_reg == '0) ? ST_FINISH : ST_DIV_INIT;
            end
            ST_DIV_INIT:
                state_next = ST_CHECK;
            ST_CHECK:
                state_next = (rem_reg >= {dvs_reg, 1'b0}) ? ST_ROUND : ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
                state_next = ST_DIFF;
            ST_DIFF:
                state_next = ST_SQUARE;
            ST_SQUARE:
                state_next = ST_ACCUM;
            ST_ACCUM:
                state_next = coord_reg ? ST_FINISH : ST_DIV_INIT;
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: datapath and output updates
    // ------------------------------------------------------------------
    always_comb
    begin
        cnt_next     = cnt_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        tx_next      = tx_reg;
        ty_next      = ty_reg;
        last_next    = last_reg;
        prod_next    = mul_p;
        den_next     = den_reg;
        nx_next      = nx_reg;
        ny_next      = ny_reg;
        r2_next      = r2_reg;
        rem_next     = rem_reg;
        dvs_next     = dvs_reg;
        q_next       = q_reg;
        neg_next     = neg_reg;
        ovf_next     = ovf_reg;
        px_next      = px_reg;
        diff_next    = diff_reg;
        err_acc_next = err_acc_reg;
        sat_next     = sat_reg;
        coord_next   = coord_reg;
        index_next   = index_reg;
        tally_next   = tally_reg;

        // Drop the held result once taken
        out_valid_next    = out_valid_reg && !out_ready;
        pair_index_next   = pair_index_reg;
        err_sq_next       = err_sq_reg;
        is_inlier_next    = is_inlier_reg;
        inlier_count_next = inlier_count_reg;
        end_of_set_next   = end_of_set_reg;

        case (state_reg)
            // Capture the word and clear per-word state
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    x_next       = from_x;
                    y_next       = from_y;
                    tx_next      = to_x;
                    ty_next      = to_y;
                    last_next    = last_pair;
                    cnt_next     = '0;
                    err_acc_next = '0;
                    sat_next     = 1'b0;
                    coord_next   = 1'b0;
                end
            end
            // Accumulate the registered product issued at the previous step
            ST_MAC:
            begin
                cnt_next = cnt_reg + 6'd1;
                case (cnt_reg)
                    6'd1: den_next = DEN_ONE + prod_ext;
                    6'd2: den_next = den_reg + prod_ext;
                    6'd3: nx_next  = {{(NUM_W - 36){h_xt_reg[31]}}, h_xt_reg, 4'b0}
                                     + prod_ext;
                    6'd4: nx_next  = nx_reg + prod_ext;
                    6'd5: ny_next  = {{(NUM_W - 36){h_yt_reg[31]}}, h_yt_reg, 4'b0}
                                     + prod_ext;
                    6'd6: ny_next  = ny_reg + prod_ext;
                    6'd7:
                    begin
                        r2_next = prod_reg[31:0];
                        if (den_reg == '0)
                            sat_next = 1'b1;
                    end
                    default: ;
                endcase
            end
            // Load magnitudes, divisor aligned to the top quotient bit
            ST_DIV_INIT:
            begin
                rem_next = {{(REM_W - NUM_W){1'b0}}, num_mag};
                dvs_next = {den_mag[NUM_W-2:0], {(DVS_W - NUM_W + 1){1'b0}}};
                neg_next = num_sel[NUM_W-1] ^ den_reg[NUM_W-1];
                q_next   = '0;
            end
            // Flag quotients too large for the integer field
            ST_CHECK:
            begin
                ovf_next = (rem_reg >= {dvs_reg, 1'b0});
                cnt_next = '0;
            end
            // Retire one quotient bit
            ST_DIV:
            begin
                rem_next = {rem_sub[REM_W-2:0], 1'b0};
                q_next   = {q_reg[Q_W-2:0], div_ge};
                cnt_next = cnt_reg + 6'd1;
            end
            // Round half away from zero and apply the sign
            ST_ROUND:
            begin
                px_next = neg_reg ? (~{1'b0, q_mag} + 1'b1) : {1'b0, q_mag};
            end
            ST_DIFF:
            begin
                diff_next = {px_reg[PX_W-1], px_reg}
                            - {{(DIF_W - 18){t_sel[17]}}, t_sel};
            end
            // Square on the shared multiplier, flag large differences
            ST_SQUARE:
            begin
                if (diff_mag[DIF_W-1:16] != '0)
                    sat_next = 1'b1;
            end
            ST_ACCUM:
            begin
                err_acc_next = err_acc_reg + {1'b0, prod_reg[31:0]};
                coord_next   = 1'b1;
            end
            // Load the result word and advance the set counters, clearing them after the last pair
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    pair_index_next   = index_reg;
                    err_sq_next       = err_final;
                    is_inlier_next    = inl_final;
                    inlier_count_next = tally_inc;
                    end_of_set_next   = last_reg;
                    if (last_reg)
                    begin
                        index_next = '0;
                        tally_next = '0;
                    end
                    else
                    begin
                        tally_next = tally_inc;
                        if (index_reg < IDX_TOP)
                            index_next = index_reg + 16'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            index_reg     <= '0;
            tally_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            index_reg     <= index_next;
            tally_reg     <= tally_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg            <= x_next;
        y_reg            <= y_next;
        tx_reg           <= tx_next;
        ty_reg           <= ty_next;
        last_reg         <= last_next;
        prod_reg         <= prod_next;
        den_reg          <= den_next;
        nx_reg           <= nx_next;
        ny_reg           <= ny_next;
        r2_reg           <= r2_next;
        rem_reg          <= rem_next;
        dvs_reg          <= dvs_next;
        q_reg            <= q_next;
        neg_reg          <= neg_next;
        ovf_reg          <= ovf_next;
        px_reg           <= px_next;
        diff_reg         <= diff_next;
        err_acc_reg      <= err_acc_next;
        sat_reg          <= sat_next;
        coord_reg        <= coord_next;
        pair_index_reg   <= pair_index_next;
        err_sq_reg       <= err_sq_next;
        is_inlier_reg    <= is_inlier_next;
        inlier_count_reg <= inlier_count_next;
        end_of_set_reg   <= end_of_set_next;
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign pair_index   = pair_index_reg;
    assign err_sq       = err_sq_reg;
    assign is_inlier    = is_inlier_reg;
    assign inlier_count = inlier_count_reg;
    assign end_of_set   = end_of_set_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // One word at a time: no second accept right after an accept
    a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while a word is in flight");

    // The count of inliers never runs ahead of the pair position
    a_tally_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, inlier_count} <= ({2'b0, pair_index} + 18'd1)))
        else $error("inlier count exceeds pair index plus one");

    // A saturated error is never an inlier
    a_sat_outlier: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_inlier) |-> (err_sq != ERR_SAT))
        else $error("saturated error flagged as inlier");

    // The divider stops after its last quotient bit
    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg <= DIV_LAST))
        else $error("divider step count out of range");

    // A result is loaded only from the finishing step
    a_load_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == ST_FINISH))
        else $error("result loaded outside the finishing step");

endmodule
`default_nettype wire

/* sim/homography_reprojection_inlier_test_test.sv */
`timescale 1ns / 100ps
// ============================================================================
// homography_reprojection_inlier_test_test
// Self-checking bench for the homography reprojection inlier test. A driver
// feeds correspondence words from a queue, a monitor checks each result word
// against a local fixed-point predictor of the projective map, squared error,
// inlier flag and per-set counters. Several matrix settings are loaded over
// the register port, extremes included, and a closing set of zero-denominator
// words runs back to back with the result side always ready.
// ============================================================================
module homography_reprojection_inlier_test_test
    import hrit_pkg::*;
();

    typedef struct packed {
        logic signed [17:0] fx;
        logic signed [17:0] fy;
        logic signed [17:0] tx;
        logic signed [17:0] ty;
        logic               last;
        logic               drain_first;
    } pair_word_t;

    typedef struct packed {
        logic [15:0] idx;
        logic [31:0] err;
        logic        inl;
        logic [16:0] cnt;
        logic        eos;
    } score_t;

    // Clock, reset and block ports
    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [63:0]           pwdata = '0;
    logic [63:0]           prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic signed [17:0]    from_x = '0;
    logic signed [17:0]    from_y = '0;
    logic signed [17:0]    to_x = '0;
    logic signed [17:0]    to_y = '0;
    logic                  last_pair = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [15:0]           pair_index;
    logic [31:0]           err_sq;
    logic                  is_inlier;
    logic [16:0]           inlier_count;
    logic                  end_of_set;

    // Local copy of the registers and of the set counters
    logic [63:0] cfg_mirror [8];
    logic [15:0] set_idx = '0;
    logic [16:0] set_tally = '0;

    pair_word_t pairs_to_send [$];
    score_t     pending_scores [$];
    pair_word_t cur_pair;
    score_t     want;

    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    bit          send_quiet = 1'b0;
    bit          hold_quiet = 1'b0;
    bit          idle_off = 1'b0;

    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned sets_seen = 0;
    int unsigned inliers_seen = 0;
    int unsigned saturated_seen = 0;
    int unsigned settings_used = 0;
    int unsigned deepest_index = 0;

    homography_reprojection_inlier_test dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .from_x       (from_x),
        .from_y       (from_y),
        .to_x         (to_x),
        .to_y         (to_y),
        .last_pair    (last_pair),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pair_index   (pair_index),
        .err_sq       (err_sq),
        .is_inlier    (is_inlier),
        .inlier_count (inlier_count),
        .end_of_set   (end_of_set)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Rounded quotient n * 2^18 / d with four fraction bits, clamped to 2^40
    function automatic longint signed quotient_q4(input longint signed n,
                                                  input longint signed d);
        longint unsigned an;
        longint unsigned ad;
        longint unsigned q;
        longint unsigned r;
        int i;
        an = (n < 0) ? -n : n;
        ad = (d < 0) ? -d : d;
        q = an / ad;
        if (q >= (64'd1 << 22))
        begin
            q = 64'd1 << 40;
        end
        else
        begin
            r = an % ad;
            for (i = 0; i < 19; i++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= ad)
                begin
                    r = r - ad;
                    q = q | 64'd1;
                end
            end
            q = (q + 64'd1) >> 1;
            if (q > (64'd1 << 40))
                q = 64'd1 << 40;
        end
        return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
    endfunction

    // Map a source point; returns 1 when the denominator is zero
    function automatic bit map_point(input logic signed [17:0] fx,
                                     input logic signed [17:0] fy,
                                     output longint signed px,
                                     output longint signed py);
        longint signed x;
        longint signed y;
        longint signed den;
        longint signed nx;
        longint signed ny;
        longint signed h [6];
        longint signed h6;
        longint signed h7;
        x = fx;
        y = fy;
        h[0] = $signed(cfg_mirror[REG_H_XX][31:0]);
        h[1] = $signed(cfg_mirror[REG_H_XY][31:0]);
        h[2] = $signed(cfg_mirror[REG_H_XT][31:0]);
        h[3] = $signed(cfg_mirror[REG_H_YX][31:0]);
        h[4] = $signed(cfg_mirror[REG_H_YY][31:0]);
        h[5] = $signed(cfg_mirror[REG_H_YT][31:0]);
        h6 = $signed(cfg_mirror[REG_H_PERSP][31:0]);
        h7 = $signed(cfg_mirror[REG_H_PERSP][63:32]);
        den = h6 * x + h7 * y + (64'sd1 <<< 34);
        nx = h[0] * x + h[1] * y + h[2] * 64'sd16;
        ny = h[3] * x + h[4] * y + h[5] * 64'sd16;
        px = 0;
        py = 0;
        if (den == 0)
            return 1'b1;
        px = quotient_q4(nx, den);
        py = quotient_q4(ny, den);
        return 1'b0;
    endfunction

    function automatic longint unsigned square_gap(input longint signed p,
                                                   input longint signed t,
                                                   inout bit sat);
        longint signed dv;
        longint unsigned m;
        dv = p - t;
        m = (dv < 0) ? -dv : dv;
        if (m >= 64'd65536)
        begin
            sat = 1'b1;
            return 0;
        end
        return m * m;
    endfunction

    // Score one accepted correspondence and advance the set counters
    function automatic score_t project_and_score(input pair_word_t w);
        longint signed px;
        longint signed py;
        longint unsigned total;
        longint unsigned rad;
        bit flat;
        bit sat;
        bit inl;
        score_t s;
        sat = 1'b0;
        inl = 1'b0;
        total = 64'hFFFF_FFFF;
        flat = map_point(w.fx, w.fy, px, py);
        if (!flat)
        begin
            total = square_gap(px, $signed(w.tx), sat) + square_gap(py, $signed(w.ty), sat);
            if (sat || total > 64'hFFFF_FFFF)
                total = 64'hFFFF_FFFF;
            rad = cfg_mirror[REG_RADIUS][15:0];
            inl = total < rad * rad;
        end
        if (inl && set_tally < TALLY_TOP)
            set_tally = set_tally + 17'd1;
        s.idx = set_idx;
        s.err = total[31:0];
        s.inl = inl;
        s.cnt = set_tally;
        s.eos = w.last;
        if (w.last)
        begin
            set_idx = '0;
            set_tally = '0;
        end
        else if (set_idx < IDX_TOP)
        begin
            set_idx = set_idx + 16'd1;
        end
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [17:0] near_target(input longint signed p,
                                                input int unsigned spread);
        longint signed t;
        t = p + longint'($urandom_range(0, 2 * spread)) - longint'(spread);
        if (t > 131071 || t < -131072)
            return 18'($urandom);
        return t[17:0];
    endfunction

    // Well-formed correspondences land near the mapped point; the rest is noise
    function automatic pair_word_t random_pair(input int unsigned spread);
        pair_word_t w;
        longint signed px;
        longint signed py;
        bit flat;
        w.fx = 18'($urandom);
        w.fy = 18'($urandom);
        if ($urandom_range(0, 99) >= 35)
        begin
            w.fx = 18'(int'($urandom_range(0, 16383)) - 8192);
            w.fy = 18'(int'($urandom_range(0, 16383)) - 8192);
        end
        flat = map_point(w.fx, w.fy, px, py);
        if (!flat && $urandom_range(0, 99) < 80)
        begin
            w.tx = near_target(px, spread);
            w.ty = near_target(py, spread);
        end
        else if ($urandom_range(0, 1) == 0)
        begin
            w.tx = 18'($urandom);
            w.ty = 18'($urandom);
        end
        else
        begin
            w.tx = 18'(int'($urandom_range(0, 16383)) - 8192);
            w.ty = 18'(int'($urandom_range(0, 16383)) - 8192);
        end
        w.last = ($urandom_range(0, 15) == 0);
        w.drain_first = ($urandom_range(0, 59) == 0);
        return w;
    endfunction

    task automatic queue_pair(input int fx, input int fy, input int tx, input int ty,
                              input bit last, input bit drain_first);
        pair_word_t w;
        w.fx = 18'(fx);
        w.fy = 18'(fy);
        w.tx = 18'(tx);
        w.ty = 18'(ty);
        w.last = last;
        w.drain_first = drain_first;
        pairs_to_send = {pairs_to_send, w};
    endtask

    // Setup and access cycle; the register takes the value on the access edge
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_H_PERSP)
            cfg_mirror[idx] = value;
        else if (idx == REG_RADIUS)
            cfg_mirror[idx] = {48'd0, value[15:0]};
        else
            cfg_mirror[idx] = {32'd0, value[31:0]};
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pairs_to_send.size() != 0 || in_valid || pending_scores.size() != 0);
    endtask

    function automatic logic [31:0] near_one();
        return 32'(65536 + int'($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic logic [31:0] small_term(input int unsigned bits);
        return 32'(int'($urandom_range(0, 2 ** (bits + 1))) - 2 ** bits);
    endfunction

    // Load a full matrix setting: extremes, fully random, or near identity
    task automatic load_setting(input int unsigned kind);
        logic [31:0] m [6];
        logic [63:0] persp;
        logic [15:0] rad;
        int unsigned pbits;
        int i;
        case (kind)
            0:
            begin
                for (i = 0; i < 6; i++)
                    m[i] = 32'h7FFF_FFFF;
                persp = 64'h7FFF_FFFF_7FFF_FFFF;
                rad = 16'hFFFF;
            end
            1:
            begin
                for (i = 0; i < 6; i++)
                    m[i] = 32'h8000_0000;
                persp = 64'h8000_0000_8000_0000;
                rad = 16'h0000;
            end
            2:
            begin
                for (i = 0; i < 6; i++)
                    m[i] = $urandom;
                persp = {$urandom, $urandom};
                rad = 16'($urandom);
            end
            default:
            begin
                pbits = (kind % 3 == 0) ? 18 : 13;
                m[0] = near_one();
                m[1] = small_term(14);
                m[2] = small_term(22);
                m[3] = small_term(14);
                m[4] = near_one();
                m[5] = small_term(22);
                persp = {small_term(pbits), small_term(pbits)};
                rad = (kind == 4) ? 16'hFFFF : 16'($urandom_range(0, 1023));
            end
        endcase
        write_reg(REG_H_XX, {32'd0, m[0]});
        write_reg(REG_H_XY, {32'd0, m[1]});
        write_reg(REG_H_XT, {32'd0, m[2]});
        write_reg(REG_H_YX, {32'd0, m[3]});
        write_reg(REG_H_YY, {32'd0, m[4]});
        write_reg(REG_H_YT, {32'd0, m[5]});
        write_reg(REG_H_PERSP, persp);
        write_reg(REG_RADIUS, {48'd0, rad});
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // Driver: present queued words, predict on acceptance
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                pending_scores = {pending_scores, project_and_score(cur_pair)};
                gap_left = (idle_off || send_quiet) ? 0 : pick_gap();
                if ($urandom_range(0, 49) == 0)
                    send_quiet = !send_quiet;
            end
            // Slot is free after this edge: count down the gap, then load
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    if (in_ready)
                        gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pairs_to_send.size() > 0 &&
                         !(pairs_to_send[0].drain_first && pending_scores.size() > 0))
                begin
                    cur_pair = pairs_to_send.pop_front();
                    from_x <= cur_pair.fx;
                    from_y <= cur_pair.fy;
                    to_x <= cur_pair.tx;
                    to_y <= cur_pair.ty;
                    last_pair <= cur_pair.last;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result side back-pressure, with quiet stretches
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 299) == 0)
                hold_quiet = !hold_quiet;
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!idle_off && !hold_quiet && $urandom_range(0, 5) == 0)
            begin
                stall_left = pick_gap();
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] wanted);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch on result word %0d: %s is 0x%0h, predicted 0x%0h",
                     results_seen, what, got, wanted);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_scores.size() == 0)
            begin
                report_mismatch("word with nothing pending, err_sq", {32'd0, err_sq}, 64'd0);
            end
            else
            begin
                want = pending_scores.pop_front();
                if (pair_index !== want.idx)
                    report_mismatch("pair_index", {48'd0, pair_index}, {48'd0, want.idx});
                if (err_sq !== want.err)
                    report_mismatch("err_sq", {32'd0, err_sq}, {32'd0, want.err});
                if (is_inlier !== want.inl)
                    report_mismatch("is_inlier", {63'd0, is_inlier}, {63'd0, want.inl});
                if (inlier_count !== want.cnt)
                    report_mismatch("inlier_count", {47'd0, inlier_count}, {47'd0, want.cnt});
                if (end_of_set !== want.eos)
                    report_mismatch("end_of_set", {63'd0, end_of_set}, {63'd0, want.eos});
                if (want.eos)
                    sets_seen++;
                if (want.inl)
                    inliers_seen++;
                if (want.err == ERR_SAT)
                    saturated_seen++;
                if (want.idx > deepest_index)
                    deepest_index = want.idx;
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int k;
        int n;
        int unsigned rad;
        int unsigned spread;
        cfg_mirror[REG_H_XX] = 64'd65536;
        cfg_mirror[REG_H_XY] = 64'd0;
        cfg_mirror[REG_H_XT] = 64'd0;
        cfg_mirror[REG_H_YX] = 64'd0;
        cfg_mirror[REG_H_YY] = 64'd65536;
        cfg_mirror[REG_H_YT] = 64'd0;
        cfg_mirror[REG_H_PERSP] = 64'd0;
        cfg_mirror[REG_RADIUS] = 64'd0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset setting: identity map, zero radius, field extremes
        queue_pair(0, 0, 0, 0, 1'b0, 1'b0);
        queue_pair(131071, -131072, 131071, -131072, 1'b0, 1'b0);
        queue_pair(131071, 0, -131072, 0, 1'b0, 1'b0);
        queue_pair(-131072, -131072, 131071, 131071, 1'b1, 1'b0);
        wait_idle();

        // Widest radius: error boundaries around the largest radius squared
        write_reg(REG_RADIUS, 64'hFFFF);
        settings_used++;
        queue_pair(100, -100, 100, -100, 1'b0, 1'b0);
        queue_pair(0, 0, 50000, 50000, 1'b0, 1'b0);
        queue_pair(65535, 0, 0, 0, 1'b0, 1'b0);
        queue_pair(65534, 0, 0, 0, 1'b0, 1'b0);
        queue_pair(-65536, 0, 0, 0, 1'b0, 1'b0);
        queue_pair(7, 9, 7, 9, 1'b1, 1'b1);
        wait_idle();

        // Perspective row -1.0 on x and a tiny y term: zero and tiny denominators
        write_reg(REG_H_PERSP, 64'h0000_0001_C000_0000);
        write_reg(REG_RADIUS, 64'd16);
        settings_used++;
        queue_pair(16, 0, 0, 0, 1'b0, 1'b0);
        queue_pair(16, 1, 0, 0, 1'b0, 1'b0);
        queue_pair(16, -1, 0, 0, 1'b0, 1'b0);
        queue_pair(0, 0, 0, 0, 1'b0, 1'b0);
        queue_pair(32, 0, -32, 0, 1'b1, 1'b0);
        queue_pair(16, 0, 5, 5, 1'b1, 1'b0);
        wait_idle();

        // Random correspondences over a sweep of settings
        for (k = 0; k < 8; k++)
        begin
            load_setting(k);
            rad = cfg_mirror[REG_RADIUS][15:0];
            spread = (rad < 8) ? 8 : ((rad > 4096) ? 4096 : rad);
            n = (k < 2) ? 80 : ((k == 2) ? 150 : 300);
            repeat (n) pairs_to_send = {pairs_to_send, random_pair(spread)};
            wait_idle();
        end

        // One set of zero-denominator words, back to back, result side always ready
        idle_off = 1'b1;
        write_reg(REG_H_PERSP, 64'h0000_0000_C000_0000);
        settings_used++;
        n = 60;
        for (k = 0; k < n; k++)
            queue_pair(16, int'($urandom), int'($urandom), int'($urandom), k == n - 1, 1'b0);
        wait_idle();

        // Let any stray result word show up
        repeat (150) @(posedge clk);
        $display("checked %0d result words in %0d sets over %0d settings",
                 results_seen, sets_seen, settings_used);
        $display("%0d inliers, %0d saturated errors, deepest pair index %0d",
                 inliers_seen, saturated_seen, deepest_index);
        if (mismatches == 0)
            $display("homography_reprojection_inlier_test_test: PASS");
        else
            $display("homography_reprojection_inlier_test_test: FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(100_000_000);
        $display("timeout with %0d result words still pending", pending_scores.size());
        $display("homography_reprojection_inlier_test_test: FAIL");
        $finish;
    end

endmodule
